// ----- rtl/rfu_pkg.sv -----
// shared sizes for the refraction and fresnel unit
// used by the divider, the square root and the top level
`timescale 1ns / 1ps

package rfu_pkg;

  // restoring divider: quotient bits, numerator and divisor widths
  localparam int DIV_Q_W   = 18;
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 35;

  // integer square root: one result bit per stage
  localparam int SQ_STEPS  = 15;
  localparam int SQ_ARG_W  = 2 * SQ_STEPS - 1;

endpackage

// ----- rtl/rfu_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on rfu_pkg; numerator must stay below den * 2^DIV_Q_W
`timescale 1ns / 1ps

module rfu_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [rfu_pkg::DIV_NUM_W-1:0] mag,
  input  logic [rfu_pkg::DIV_DEN_W-1:0] den,
  output logic [rfu_pkg::DIV_Q_W-1:0]   quo
);
  import rfu_pkg::*;

  logic [DIV_NUM_W-1:0] rem   [1:DIV_Q_W-1];
  logic [DIV_DEN_W-1:0] dv    [1:DIV_Q_W-1];
  logic [DIV_Q_W-1:0]   qt    [1:DIV_Q_W];
  logic [DIV_NUM_W-1:0] cur_r [0:DIV_Q_W-1];
  logic [DIV_DEN_W-1:0] cur_d [0:DIV_Q_W-1];
  logic [DIV_Q_W-1:0]   cur_q [0:DIV_Q_W-1];
  logic [DIV_NUM_W-1:0] sh    [0:DIV_Q_W-1];

  always_comb begin
    cur_r[0] = mag;
    cur_d[0] = den;
    cur_q[0] = '0;
    for (int j = 1; j < DIV_Q_W; j++) begin
      cur_r[j] = rem[j];
      cur_d[j] = dv[j];
      cur_q[j] = qt[j];
    end
    for (int j = 0; j < DIV_Q_W; j++) begin
      sh[j] = DIV_NUM_W'(cur_d[j]) << (DIV_Q_W - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_Q_W - 1; j++) begin
        if (cur_r[j] >= sh[j]) begin
          rem[j+1] <= cur_r[j] - sh[j];
        end else begin
          rem[j+1] <= cur_r[j];
        end
        dv[j+1] <= cur_d[j];
      end
      for (int j = 0; j < DIV_Q_W; j++) begin
        if (cur_r[j] >= sh[j]) begin
          qt[j+1] <= {cur_q[j][DIV_Q_W-2:0], 1'b1};
        end else begin
          qt[j+1] <= {cur_q[j][DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qt[DIV_Q_W];

endmodule

// ----- rtl/rfu_sqrt.sv -----
// pipelined integer square root, floor of the root, one bit per stage
// depends on rfu_pkg
`timescale 1ns / 1ps

module rfu_sqrt (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [rfu_pkg::SQ_ARG_W-1:0] arg,
  output logic [rfu_pkg::SQ_STEPS-1:0] root
);
  import rfu_pkg::*;

  localparam int SQ_W = SQ_ARG_W + 1;

  logic [SQ_W-1:0] xr    [1:SQ_STEPS-1];
  logic [SQ_W-1:0] rr    [1:SQ_STEPS];
  logic [SQ_W-1:0] cur_x [0:SQ_STEPS-1];
  logic [SQ_W-1:0] cur_r [0:SQ_STEPS-1];
  logic [SQ_W-1:0] bitv  [0:SQ_STEPS-1];
  logic [SQ_W-1:0] trial [0:SQ_STEPS-1];

  always_comb begin
    cur_x[0] = SQ_W'(arg);
    cur_r[0] = '0;
    for (int j = 1; j < SQ_STEPS; j++) begin
      cur_x[j] = xr[j];
      cur_r[j] = rr[j];
    end
    for (int j = 0; j < SQ_STEPS; j++) begin
      bitv[j]  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
      trial[j] = cur_r[j] + bitv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < SQ_STEPS - 1; j++) begin
        if (cur_x[j] >= trial[j]) begin
          xr[j+1] <= cur_x[j] - trial[j];
        end else begin
          xr[j+1] <= cur_x[j];
        end
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
        if (cur_x[j] >= trial[j]) begin
          rr[j+1] <= (cur_r[j] >> 1) + bitv[j];
        end else begin
          rr[j+1] <= cur_r[j] >> 1;
        end
      end
    end
  end

  assign root = rr[SQ_STEPS][SQ_STEPS-1:0];

endmodule

// ----- rtl/refraction_fresnel_unit_core.sv -----
// top level of the refraction and fresnel unit
// depends on rfu_pkg, rfu_div and rfu_sqrt
`timescale 1ns / 1ps

// Takes one ray-surface hit per cycle while hit_stall is low and returns the Snell
// refracted direction, the squared refracted sine and the unpolarized Fresnel
// reflectance, flagging total internal reflection. One hit enters every cycle unless
// hit_stall is high. Each result passes six front stages, an 18-stage divider for
// the tangential part, three stages, a 15-stage square root, two stages, an 18-stage
// divider for the Fresnel ratios, three final stages, then the output buffer
// register. A two-beat output buffer holds results, so hits keep being taken while
// one result waits; hit_stall rises only when both buffer slots are full.

module refraction_fresnel_unit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               hit_valid,
  output logic               hit_stall,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic               entering,
  input  logic        [15:0] index_from,
  input  logic        [15:0] index_to,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [15:0] refr_x,
  output logic signed [15:0] refr_y,
  output logic signed [15:0] refr_z,
  output logic        [17:0] sine_sq,
  output logic               total_reflect,
  output logic        [16:0] reflectance
);
  import rfu_pkg::*;

  localparam int LAT = 14 + 2 * DIV_Q_W + SQ_STEPS;

  typedef struct packed {
    logic [2:0][15:0] n;
    logic             ent;
    logic [15:0]      n1;
    logic [15:0]      n2;
  } geo_t;

  typedef struct packed {
    geo_t        g;
    logic [17:0] c1;
    logic [2:0]  neg;
    logic [2:0]  ovf;
  } side_a_t;

  typedef struct packed {
    geo_t             g;
    logic [2:0][18:0] v;
    logic [17:0]      c1;
    logic [17:0]      sine;
    logic             tir;
  } side_b_t;

  typedef struct packed {
    logic [2:0][15:0] refr;
    logic [17:0]      sine;
    logic             tir;
    logic             neg1;
    logic             neg2;
    logic             z1;
    logic             z2;
  } side_c_t;

  typedef struct packed {
    logic [2:0][15:0] refr;
    logic [17:0]      sine;
    logic             tir;
    logic [16:0]      refl;
  } res_t;

  logic           adv;
  logic [LAT-1:0] vld;
  logic [1:0]     cnt;
  logic           push;
  logic           pop;
  res_t           head;
  res_t           skid;

  // front stages
  geo_t               g1, g2, g3, g4, g5, g6, g7, g8, g9;
  logic signed [15:0] d1 [3];
  logic signed [15:0] d2 [3];
  logic signed [15:0] d3 [3];
  logic signed [31:0] pr1 [3];
  logic signed [33:0] dot2, dot3;
  logic signed [49:0] pd3 [3];
  logic signed [20:0] t4 [3];
  logic signed [20:0] t4_next [3];
  logic        [17:0] c1_4, c1_4_next, c1_5, c1_6, c1_7, c1_8, c1_9;
  logic signed [37:0] tn5 [3];
  logic        [15:0] div5;
  logic [DIV_NUM_W-1:0] mag6 [3];
  logic [DIV_NUM_W-1:0] mag6_next [3];
  logic [DIV_DEN_W-1:0] den6;
  logic [2:0]         neg6, neg6_next, ovf6, ovf6_next;
  side_a_t            dla [1:DIV_Q_W];
  logic [DIV_Q_W-1:0] q_vx [3];

  // middle stages
  logic signed [18:0] v7 [3];
  logic signed [18:0] v7_next [3];
  logic signed [18:0] v8 [3];
  logic signed [18:0] v9 [3];
  logic        [34:0] sq8 [3];
  logic        [17:0] sine9, sine9_next;
  logic               tir9, tir9_next;
  logic [SQ_ARG_W-1:0] arg9, arg9_next;
  side_b_t            dlb [1:SQ_STEPS];
  logic [SQ_STEPS-1:0] root;

  // back stages
  logic               ent10, tir10;
  logic        [17:0] sine10;
  logic signed [18:0] v10 [3];
  logic signed [31:0] cn10 [3];
  logic        [33:0] a10, b2_10;
  logic        [30:0] b10, a2_10;
  side_c_t            c11, c11_next, c12, c13;
  logic [DIV_NUM_W-1:0] m1_11, m2_11, m1_next, m2_next;
  logic [DIV_DEN_W-1:0] e1_11, e2_11, e1_next, e2_next;
  side_c_t            dlc [1:DIV_Q_W];
  logic [DIV_Q_W-1:0] q1, q2;
  logic signed [17:0] o12, p12, o12_next, p12_next;
  logic        [32:0] osq13, psq13;
  res_t               r14, r14_next;

  // flow control: the pipeline moves whenever the output buffer has a free slot
  assign adv       = (cnt != 2'd2);
  assign hit_stall = !adv;
  assign push      = vld[LAT-1] && adv;
  assign pop       = (cnt != 2'd0) && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], hit_valid};
    end
  end

  // stage 1 to 3: dot product and its projection on the normal
  always_ff @(posedge clk) begin
    if (adv) begin
      g1.n[0] <= norm_x;
      g1.n[1] <= norm_y;
      g1.n[2] <= norm_z;
      g1.ent  <= entering;
      g1.n1   <= index_from;
      g1.n2   <= index_to;
      d1[0]   <= dir_x;
      d1[1]   <= dir_y;
      d1[2]   <= dir_z;
      pr1[0]  <= 32'(dir_x) * 32'(norm_x);
      pr1[1]  <= 32'(dir_y) * 32'(norm_y);
      pr1[2]  <= 32'(dir_z) * 32'(norm_z);
      g2      <= g1;
      d2      <= d1;
      dot2    <= 34'(pr1[0]) + 34'(pr1[1]) + 34'(pr1[2]);
      g3      <= g2;
      d3      <= d2;
      dot3    <= dot2;
      for (int i = 0; i < 3; i++) begin
        pd3[i] <= 50'(dot2) * 50'($signed(g2.n[i]));
      end
    end
  end

  // stage 4: tangent part and cosine of the incident angle
  always_comb begin
    logic signed [50:0] rs;
    logic        [33:0] adot;
    rs   = '0;
    for (int i = 0; i < 3; i++) begin
      rs         = 51'(pd3[i]) + 51'sd134217728;
      t4_next[i] = 21'(d3[i]) - 21'(rs >>> 28);
    end
    adot      = dot3[33] ? 34'(-dot3) : 34'(dot3);
    c1_4_next = 18'((adot + 34'd8192) >> 14);
  end

  // stage 5 and 6: scale by the source index, prepare the divide
  always_comb begin
    logic [37:0] atn;
    logic [37:0] magv;
    logic [37:0] lim;
    atn  = '0;
    magv = '0;
    lim  = {5'b0, div5, 17'b0} + 38'(div5);
    for (int i = 0; i < 3; i++) begin
      atn          = tn5[i][37] ? 38'(-tn5[i]) : 38'(tn5[i]);
      magv         = atn + 38'(div5 >> 1);
      neg6_next[i] = tn5[i][37];
      ovf6_next[i] = (magv >= lim);
      mag6_next[i] = ovf6_next[i] ? '0 : DIV_NUM_W'(magv);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g4   <= g3;
      t4   <= t4_next;
      c1_4 <= c1_4_next;
      g5   <= g4;
      c1_5 <= c1_4;
      for (int i = 0; i < 3; i++) begin
        tn5[i] <= 38'(t4[i]) * 38'($signed({1'b0, g4.n1}));
      end
      div5 <= (g4.n2 == 16'd0) ? 16'd1 : g4.n2;
      g6   <= g5;
      c1_6 <= c1_5;
      mag6 <= mag6_next;
      den6 <= DIV_DEN_W'(div5);
      neg6 <= neg6_next;
      ovf6 <= ovf6_next;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_vx
    rfu_div u_div (
      .clk (clk),
      .adv (adv),
      .mag (mag6[i]),
      .den (den6),
      .quo (q_vx[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dla[1].g   <= g6;
      dla[1].c1  <= c1_6;
      dla[1].neg <= neg6;
      dla[1].ovf <= ovf6;
      for (int j = 2; j <= DIV_Q_W; j++) begin
        dla[j] <= dla[j-1];
      end
    end
  end

  // stage 7 to 9: signed tangent, squared sine, total reflection
  always_comb begin
    logic signed [18:0] m19;
    m19 = '0;
    for (int i = 0; i < 3; i++) begin
      m19        = dla[DIV_Q_W].ovf[i] ? 19'sd131072 : $signed(19'(q_vx[i]));
      v7_next[i] = dla[DIV_Q_W].neg[i] ? -m19 : m19;
    end
  end

  always_comb begin
    logic [35:0] ss;
    logic [21:0] s;
    logic [14:0] diff;
    ss         = 36'(sq8[0]) + 36'(sq8[1]) + 36'(sq8[2]);
    s          = 22'((ss + 36'd8192) >> 14);
    tir9_next  = (s > 22'd16384);
    sine9_next = (s > 22'd262143) ? 18'd262143 : s[17:0];
    diff       = 15'(22'd16384 - s);
    arg9_next  = tir9_next ? '0 : {diff, 14'b0};
  end

  always_ff @(posedge clk) begin
    logic signed [37:0] p;
    if (adv) begin
      g7    <= dla[DIV_Q_W].g;
      c1_7  <= dla[DIV_Q_W].c1;
      v7    <= v7_next;
      g8    <= g7;
      c1_8  <= c1_7;
      v8    <= v7;
      for (int i = 0; i < 3; i++) begin
        p      = 38'(v7[i]) * 38'(v7[i]);
        sq8[i] <= 35'(p);
      end
      g9    <= g8;
      c1_9  <= c1_8;
      v9    <= v8;
      sine9 <= sine9_next;
      tir9  <= tir9_next;
      arg9  <= arg9_next;
    end
  end

  rfu_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .arg  (arg9),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dlb[1].g    <= g9;
      dlb[1].c1   <= c1_9;
      dlb[1].sine <= sine9;
      dlb[1].tir  <= tir9;
      for (int i = 0; i < 3; i++) begin
        dlb[1].v[i] <= v9[i];
      end
      for (int j = 2; j <= SQ_STEPS; j++) begin
        dlb[j] <= dlb[j-1];
      end
    end
  end

  // stage 10 and 11: normal part, direction, fresnel numerators
  always_comb begin
    logic signed [32:0] sx;
    logic signed [32:0] rr;
    logic signed [20:0] sum;
    logic signed [34:0] num1, num2;
    logic        [34:0] an1, an2;
    sx  = '0;
    rr  = '0;
    sum = '0;
    c11_next = '0;
    for (int i = 0; i < 3; i++) begin
      sx  = ent10 ? -33'(cn10[i]) : 33'(cn10[i]);
      rr  = (sx + 33'sd8192) >>> 14;
      sum = 21'(v10[i]) + 21'(rr);
      if (sum > 21'sd32767) begin
        c11_next.refr[i] = 16'h7fff;
      end else if (sum < -21'sd32768) begin
        c11_next.refr[i] = 16'h8000;
      end else begin
        c11_next.refr[i] = 16'(sum);
      end
    end
    num1    = $signed({1'b0, a10}) - $signed({4'b0, b10});
    e1_next = {1'b0, a10} + {4'b0, b10};
    num2    = $signed({4'b0, a2_10}) - $signed({1'b0, b2_10});
    e2_next = {4'b0, a2_10} + {1'b0, b2_10};
    an1     = num1[34] ? 35'(-num1) : 35'(num1);
    an2     = num2[34] ? 35'(-num2) : 35'(num2);
    m1_next = DIV_NUM_W'({an1, 16'b0}) + DIV_NUM_W'(e1_next >> 1);
    m2_next = DIV_NUM_W'({an2, 16'b0}) + DIV_NUM_W'(e2_next >> 1);
    c11_next.sine = sine10;
    c11_next.tir  = tir10;
    c11_next.neg1 = num1[34];
    c11_next.neg2 = num2[34];
    c11_next.z1   = (e1_next == '0);
    c11_next.z2   = (e2_next == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent10  <= dlb[SQ_STEPS].g.ent;
      tir10  <= dlb[SQ_STEPS].tir;
      sine10 <= dlb[SQ_STEPS].sine;
      for (int i = 0; i < 3; i++) begin
        v10[i]  <= $signed(dlb[SQ_STEPS].v[i]);
        cn10[i] <= 32'($signed({1'b0, root})) * 32'($signed(dlb[SQ_STEPS].g.n[i]));
      end
      a10   <= 34'(dlb[SQ_STEPS].g.n2) * 34'(dlb[SQ_STEPS].c1);
      b10   <= 31'(dlb[SQ_STEPS].g.n1) * 31'(root);
      a2_10 <= 31'(dlb[SQ_STEPS].g.n2) * 31'(root);
      b2_10 <= 34'(dlb[SQ_STEPS].g.n1) * 34'(dlb[SQ_STEPS].c1);
      c11   <= c11_next;
      m1_11 <= m1_next;
      m2_11 <= m2_next;
      e1_11 <= e1_next;
      e2_11 <= e2_next;
    end
  end

  rfu_div u_div_orth (
    .clk (clk),
    .adv (adv),
    .mag (m1_11),
    .den (e1_11),
    .quo (q1)
  );

  rfu_div u_div_para (
    .clk (clk),
    .adv (adv),
    .mag (m2_11),
    .den (e2_11),
    .quo (q2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dlc[1] <= c11;
      for (int j = 2; j <= DIV_Q_W; j++) begin
        dlc[j] <= dlc[j-1];
      end
    end
  end

  // stage 12 to 14: signed ratios, squares, reflectance
  always_comb begin
    o12_next = dlc[DIV_Q_W].neg1 ? -$signed(q1) : $signed(q1);
    p12_next = dlc[DIV_Q_W].neg2 ? -$signed(q2) : $signed(q2);
    if (dlc[DIV_Q_W].z1) o12_next = 18'sd65536;
    if (dlc[DIV_Q_W].z2) p12_next = 18'sd65536;
  end

  always_comb begin
    logic [33:0] acc;
    logic [16:0] rq;
    acc = 34'(osq13) + 34'(psq13) + 34'd65536;
    rq  = acc[33:17];
    r14_next.sine = c13.sine;
    r14_next.tir  = c13.tir;
    if (c13.tir) begin
      r14_next.refr = '0;
      r14_next.refl = 17'd65536;
    end else begin
      r14_next.refr = c13.refr;
      r14_next.refl = (rq > 17'd65536) ? 17'd65536 : rq;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [35:0] po, pp;
    if (adv) begin
      c12   <= dlc[DIV_Q_W];
      o12   <= o12_next;
      p12   <= p12_next;
      c13   <= c12;
      po    = 36'(o12) * 36'(o12);
      pp    = 36'(p12) * 36'(p12);
      osq13 <= 33'(po);
      psq13 <= 33'(pp);
      r14   <= r14_next;
    end
  end

  // two-beat output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) head <= r14;
        else skid <= r14;
      end
      2'b01: begin
        head <= skid;
      end
      2'b11: begin
        head <= r14;
      end
      default: begin
      end
    endcase
  end

  assign res_valid     = (cnt != 2'd0);
  assign refr_x        = head.refr[0];
  assign refr_y        = head.refr[1];
  assign refr_z        = head.refr[2];
  assign sine_sq       = head.sine;
  assign total_reflect = head.tir;
  assign reflectance   = head.refl;

  assert property (@(posedge clk) disable iff (rst)
    res_valid && total_reflect |->
      reflectance == 17'd65536 && refr_x == 16'sd0 && refr_y == 16'sd0 && refr_z == 16'sd0)
    else $error("total reflection beat carries a direction or partial reflectance");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !total_reflect |-> sine_sq <= 18'd16384)
    else $error("squared sine above one without total reflection flag");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> reflectance <= 17'd65536)
    else $error("reflectance above one");

  assert property (@(posedge clk) disable iff (rst)
    vld[LAT-1] && adv |-> cnt != 2'd2)
    else $error("pipeline push into full output buffer");

endmodule

// ----- bench/refraction_fresnel_unit_checker.sv -----
// result checker for refraction_fresnel_unit_core: predicts every hit, compares every result
// depends only on the port widths of the block
`timescale 1ns / 1ps

module refraction_fresnel_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               hit_valid,
  input  logic               hit_stall,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic               entering,
  input  logic        [15:0] index_from,
  input  logic        [15:0] index_to,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic signed [15:0] refr_x,
  input  logic signed [15:0] refr_y,
  input  logic signed [15:0] refr_z,
  input  logic        [17:0] sine_sq,
  input  logic               total_reflect,
  input  logic        [16:0] reflectance,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic        [17:0] ssq;
    logic               tir;
    logic        [16:0] refl;
  } bend_t;

  bend_t expected_bends[$];

  function automatic longint round_up_shr(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint div_away(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint fresnel_ratio(longint num, longint den);
    if (den <= 0) return 65536;
    return div_away(num * 65536, den);
  endfunction

  function automatic longint floor_sqrt(longint x);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bend_t predict_bend();
    bend_t e;
    longint d[3], nv[3], v[3];
    longint dot, n1, n2, dv, t, ss, s, c1, c2, sg, a, b, o, p, r, rr;
    d[0] = dir_x; d[1] = dir_y; d[2] = dir_z;
    nv[0] = norm_x; nv[1] = norm_y; nv[2] = norm_z;
    n1 = index_from;
    n2 = index_to;
    dv = n2 != 0 ? n2 : 1;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += d[i] * nv[i];
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      t = d[i] - round_up_shr(dot * nv[i], 28);
      v[i] = sat(div_away(t * n1, dv), -131072, 131072);
      ss += v[i] * v[i];
    end
    s = (ss + 8192) >> 14;
    e = '0;
    e.ssq = s > 262143 ? 18'd262143 : 18'(s);
    e.tir = s > 16384;
    if (e.tir) begin
      e.refl = 17'd65536;
      return e;
    end
    c2 = floor_sqrt((16384 - s) << 14);
    c1 = ((dot < 0 ? -dot : dot) + 8192) >> 14;
    sg = entering ? -1 : 1;
    rr = sat(v[0] + round_up_shr(sg * c2 * nv[0], 14), -32768, 32767);
    e.rx = 16'(rr);
    rr = sat(v[1] + round_up_shr(sg * c2 * nv[1], 14), -32768, 32767);
    e.ry = 16'(rr);
    rr = sat(v[2] + round_up_shr(sg * c2 * nv[2], 14), -32768, 32767);
    e.rz = 16'(rr);
    a = n2 * c1;
    b = n1 * c2;
    o = fresnel_ratio(a - b, a + b);
    a = n2 * c2;
    b = n1 * c1;
    p = fresnel_ratio(a - b, a + b);
    r = (o * o + p * p + 65536) >> 17;
    e.refl = r > 65536 ? 17'd65536 : 17'(r);
    return e;
  endfunction

  assign pending = expected_bends.size();

  always @(posedge clk) begin
    bend_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (hit_valid && !hit_stall) expected_bends.push_back(predict_bend());
      if (res_valid && !res_stall) begin
        if (expected_bends.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_bends.pop_front();
          if (refr_x !== e.rx) $error("refr_x expected %0d got %0d", e.rx, refr_x);
          if (refr_y !== e.ry) $error("refr_y expected %0d got %0d", e.ry, refr_y);
          if (refr_z !== e.rz) $error("refr_z expected %0d got %0d", e.rz, refr_z);
          if (sine_sq !== e.ssq) $error("sine_sq expected %0d got %0d", e.ssq, sine_sq);
          if (total_reflect !== e.tir)
            $error("total_reflect expected %0d got %0d", e.tir, total_reflect);
          if (reflectance !== e.refl)
            $error("reflectance expected %0d got %0d", e.refl, reflectance);
          if ({refr_x, refr_y, refr_z, sine_sq, total_reflect, reflectance} !== e)
            fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// ----- bench/refraction_fresnel_unit_core_tb.sv -----
// testbench top for refraction_fresnel_unit_core: directed and random hits, random stalls
// depends on refraction_fresnel_unit_checker and the block itself
`timescale 1ns / 1ps

module refraction_fresnel_unit_core_tb;

  logic clk, rst;
  logic hit_valid, hit_stall, res_valid, res_stall;
  logic signed [15:0] dir_x, dir_y, dir_z, norm_x, norm_y, norm_z;
  logic entering;
  logic [15:0] index_from, index_to;
  logic signed [15:0] refr_x, refr_y, refr_z;
  logic [17:0] sine_sq;
  logic total_reflect;
  logic [16:0] reflectance;
  int fail_count, pending;
  int res_wait;
  bit calm;

  refraction_fresnel_unit_core u_dut (.*);
  refraction_fresnel_unit_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side stall, drawn per beat
  always @(posedge clk) begin
    int w;
    if (rst) begin
      res_wait <= 0;
      res_stall <= 0;
    end else if (res_valid && !res_stall) begin
      w = calm ? 0 : $urandom_range(0, 9);
      res_wait <= w;
      res_stall <= (w > 0);
    end else if (res_wait > 0) begin
      res_wait <= res_wait - 1;
      res_stall <= res_wait > 1;
    end else begin
      res_stall <= 0;
    end
  end

  task automatic send_hit(input logic [15:0] dx, dy, dz, nx, ny, nz,
                          input logic ent, input logic [15:0] n1, n2);
    int gap;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    norm_x <= nx; norm_y <= ny; norm_z <= nz;
    entering <= ent; index_from <= n1; index_to <= n2;
    hit_valid <= 1;
    do @(negedge clk); while (hit_stall);
    @(posedge clk);
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      hit_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic unit_vec(output logic [15:0] x, y, z);
    real a, b, c, m;
    do begin
      a = ($urandom_range(0, 20000) - 10000.0) / 10000.0;
      b = ($urandom_range(0, 20000) - 10000.0) / 10000.0;
      c = ($urandom_range(0, 20000) - 10000.0) / 10000.0;
      m = $sqrt(a * a + b * b + c * c);
    end while (m < 0.05);
    x = 16'($rtoi(a / m * 16384.0));
    y = 16'($rtoi(b / m * 16384.0));
    z = 16'($rtoi(c / m * 16384.0));
  endtask

  initial begin
    logic [15:0] dx, dy, dz, nx, ny, nz, n1, n2;
    longint dp;
    int kind;
    rst = 1;
    hit_valid = 0;
    dir_x = 0; dir_y = 0; dir_z = 0;
    norm_x = 0; norm_y = 0; norm_z = 0;
    entering = 0; index_from = 16'd8192; index_to = 16'd8192;
    calm = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send_hit(0, 0, -16384, 0, 0, 16384, 1, 8192, 12288);
    send_hit(0, 0, 16384, 0, 0, 16384, 0, 12288, 8192);
    send_hit(11585, 0, -11585, 0, 0, 16384, 1, 12288, 8192);
    send_hit(16000, 0, -3000, 0, 0, 16384, 1, 13000, 8192);
    send_hit(16384, 0, 0, 0, 0, 16384, 1, 8192, 8192);
    send_hit(0, 0, 0, 0, 0, 0, 0, 0, 8192);
    send_hit(0, 0, 0, 0, 0, 0, 1, 8192, 0);
    send_hit(9000, 5000, -12000, 0, 0, 16384, 1, 8192, 0);
    send_hit(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 16'hFFFF, 16'hFFFF);
    send_hit(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 16'hFFFF, 8192);
    send_hit(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, 8192, 16'hFFFF);
    send_hit(16'h8000, 0, 0, 0, 16'h7FFF, 0, 0, 16'hFFFF, 8192);
    send_hit(5000, -7000, 13000, 16384, 0, 0, 0, 10923, 8192);
    send_hit(-16384, 0, 0, 16384, 0, 0, 1, 16'hFFFF, 8192);

    for (int i = 0; i < 850; i++) begin
      if (i % 200 == 100) calm = ~calm;
      if (i == 425) begin
        hit_valid <= 0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        unit_vec(dx, dy, dz);
        unit_vec(nx, ny, nz);
        dp = longint'($signed(dx)) * $signed(nx) + longint'($signed(dy)) * $signed(ny)
           + longint'($signed(dz)) * $signed(nz);
        n1 = (kind < 6) ? 16'($urandom_range(8192, 20000)) : 16'($urandom_range(8192, 65535));
        n2 = (kind < 6) ? 16'($urandom_range(8192, 20000)) : 16'($urandom_range(8192, 65535));
        send_hit(dx, dy, dz, nx, ny, nz, kind == 7 ? 1'($urandom) : dp < 0, n1, n2);
      end else begin
        send_hit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom), 16'($urandom_range(8192, 65535)),
                 16'($urandom_range(8192, 65535)));
      end
    end
    hit_valid <= 0;
    @(negedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- refraction_fresnel_unit_core.f -----
rtl/rfu_pkg.sv
rtl/rfu_div.sv
rtl/rfu_sqrt.sv
rtl/refraction_fresnel_unit_core.sv
bench/refraction_fresnel_unit_checker.sv
bench/refraction_fresnel_unit_core_tb.sv
